// File: sv/dqe_pkg.sv
// Shared constants, types and index helpers for the double-ended queue engine.
`default_nettype none

package dqe_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SCALE_SHIFT = 10;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_COUNT      = 3'd4,
        ACT_CLEAR      = 3'd5,
        ACT_SCALE      = 3'd6
    } action_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } mem_wr_t;

    function automatic idx_t idx_inc(input idx_t i);
        idx_inc = (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        idx_dec = (i == '0) ? idx_t'(QUEUE_DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

endpackage

`default_nettype wire

// File: sv/dqe_store.sv
// Ring storage: one write port and one registered read port.
`default_nettype none

module dqe_store
    import dqe_pkg::*;
(
    input  wire logic    clk,
    input  wire mem_wr_t wr,
    input  wire idx_t    rd_addr,
    output word_t        rd_data
);

    word_t word_store [QUEUE_DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            word_store[wr.addr] <= wr.data;
        end
        rd_data_reg <= word_store[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/dqe_scale.sv
// Saturating multiply by 1024, shared across every word of a scale walk.
`default_nettype none

module dqe_scale
    import dqe_pkg::*;
(
    input  wire word_t word_in,
    output word_t      word_out
);

    logic [SCALE_SHIFT:0] top_bits;
    logic                 fits;

    always_comb
    begin
        top_bits = word_in[WORD_W-1 -: SCALE_SHIFT + 1];
        fits     = (top_bits == '0) || (top_bits == '1);
        if (fits)
        begin
            word_out = word_in <<< SCALE_SHIFT;
        end
        else if (word_in[WORD_W-1])
        begin
            word_out = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            word_out = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// File: sv/double_ended_queue_engine.sv
// Top level: double-ended queue of signed words with a sequencer over one store and one scaler.
//
// A command is transferred at a rising edge with start high and busy low. Each
// command yields exactly one result, shown on popped_value, was_empty,
// push_rejected and entry_count for a single cycle with done high; the
// receiver cannot stall, so capture the result on that cycle. Push, count,
// clear, a pop on an empty queue and a scale of an empty queue finish at the
// accepting edge; a pop passes on through the pop state, as the store's read
// data is registered; a scale walks the N stored words one word per cycle
// through the single saturating scaler and the one read and one write port of
// the store. busy is high only during a pop or scale walk, so a new command may
// be transferred in the same cycle that done is shown. A pop on an empty queue
// returns -1 with was_empty set; a push on a full queue stores nothing and sets
// push_rejected. Reset needs no clearing pass: words are only ever read after
// a push has written them.
`default_nettype none

module double_ended_queue_engine
    import dqe_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               action,
    input  wire logic signed [WORD_W-1:0] push_value,
    output logic                          done,
    output logic signed [WORD_W-1:0]      popped_value,
    output logic                          was_empty,
    output logic                          push_rejected,
    output logic [CNT_W-1:0]              entry_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCALE
    } state_t;

    state_t  state_reg, state_next;
    idx_t    front_reg, front_next;
    idx_t    back_reg, back_next;
    cnt_t    count_reg, count_next;
    idx_t    walk_reg, walk_next;
    cnt_t    left_reg, left_next;
    logic    done_reg, done_next;
    word_t   popped_reg, popped_next;
    logic    empty_reg, empty_next;
    logic    rej_reg, rej_next;

    mem_wr_t mem_wr;
    idx_t    rd_addr;
    word_t   rd_data;
    word_t   scaled;

    logic    full;
    logic    empty;
    idx_t    front_dec;
    idx_t    back_dec;

    dqe_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dqe_scale u_scale (
        .word_in  (rd_data),
        .word_out (scaled)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign full      = (count_reg == cnt_t'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign front_dec = idx_dec(front_reg);
    assign back_dec  = idx_dec(back_reg);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        left_next   = left_reg;
        done_next   = 1'b0;
        popped_next = popped_reg;
        empty_next  = empty_reg;
        rej_next    = rej_reg;
        mem_wr.en   = 1'b0;
        mem_wr.addr = front_dec;
        mem_wr.data = push_value;
        rd_addr     = front_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Clear the result flags; most commands finish on this edge.
                    popped_next = '0;
                    empty_next  = 1'b0;
                    rej_next    = 1'b0;
                    done_next   = 1'b1;
                    unique case (action)
                        ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = front_dec;
                                front_next  = front_dec;
                                count_next  = cnt_t'(count_reg + 1'b1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = back_reg;
                                back_next   = idx_inc(back_reg);
                                count_next  = cnt_t'(count_reg + 1'b1);
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                popped_next = '1;
                                empty_next  = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = front_reg;
                                front_next = idx_inc(front_reg);
                                count_next = cnt_t'(count_reg - 1'b1);
                                done_next  = 1'b0;
                                state_next = ST_POP;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                popped_next = '1;
                                empty_next  = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = back_dec;
                                back_next  = back_dec;
                                count_next = cnt_t'(count_reg - 1'b1);
                                done_next  = 1'b0;
                                state_next = ST_POP;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            front_next = '0;
                            back_next  = '0;
                            count_next = '0;
                        end
                        ACT_SCALE:
                        begin
                            if (!empty)
                            begin
                                // Fetch the front word and start the walk there.
                                rd_addr    = front_reg;
                                walk_next  = front_reg;
                                left_next  = count_reg;
                                done_next  = 1'b0;
                                state_next = ST_SCALE;
                            end
                        end
                        default:
                        begin
                            // Count and the unused code only report the count.
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                popped_next = rd_data;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCALE:
            begin
                // Write back the scaled word and fetch the next one in the same cycle.
                mem_wr.en   = 1'b1;
                mem_wr.addr = walk_reg;
                mem_wr.data = scaled;
                rd_addr     = idx_inc(walk_reg);
                walk_next   = idx_inc(walk_reg);
                left_next   = cnt_t'(left_reg - 1'b1);
                if (left_reg == cnt_t'(1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            walk_reg  <= '0;
            left_reg  <= '0;
            done_reg  <= 1'b0;
            empty_reg <= 1'b0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
            empty_reg <= empty_next;
            rej_reg   <= rej_next;
        end
    end

    // Popped word is payload only; qualify it with done.
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
    end

    assign done          = done_reg;
    assign popped_value  = popped_reg;
    assign was_empty     = empty_reg;
    assign push_rejected = rej_reg;
    assign entry_count   = count_reg;

    // The count never passes the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(QUEUE_DEPTH))
        else $error("stored count exceeds queue depth");

    // Back index always sits count entries past the front index.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_reg == idx_t'(front_reg + count_reg[IDX_W-1:0]))
        else $error("ring indices disagree with stored count");

    // A rejected push is only reported on a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && push_rejected |-> entry_count == cnt_t'(QUEUE_DEPTH))
        else $error("push rejected on a queue that is not full");

    // An empty pop reports -1 and leaves an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && was_empty |-> popped_value == '1 && entry_count == '0)
        else $error("empty pop result malformed");

    // A scale walk ends with a done strobe on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCALE && left_reg == cnt_t'(1) |=> done && !busy)
        else $error("scale walk did not complete");

endmodule

`default_nettype wire
